// ===== rtl/core/fss_pkg.sv =====
// Shared types, constants and helpers for the fuzzy substring/subsequence scorer.
// No dependencies; the cells, tracker, top level and checker import this package.
package fss_pkg;

    // Width of query length, subsequence index and run length (holds 0..127)
    localparam int QLEN_W     = 7;
    localparam int CHAR_W     = 8;
    localparam int QIDX_W     = 6;
    localparam int SPOS_W     = 8;
    localparam int SSCORE_W   = 13;
    localparam int SCORE_W    = 14;

    // Scoring constants
    localparam int SPOS_MAX       = 255;
    localparam int SCORE_BASE     = 10000;
    localparam int SCORE_HEAD     = 10500;
    localparam int START_BONUS    = 50;
    localparam int MATCH_BASE     = 5;
    localparam int START_WINDOW   = 3;

    // Input opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // Broadcast from the control side to every cell
    typedef struct packed {
        logic              step;   // consume the current character
        logic              clear;  // end of target, drop partial matches
        logic [CHAR_W-1:0] tchar;  // folded character (load data or target char)
        logic [QLEN_W-1:0] qlen;   // effective query length
        logic [QLEN_W-1:0] sidx;   // subsequence pointer
    } cell_ctrl_t;

    // Per-cell status toward the tracker
    typedef struct packed {
        logic tail;     // full query match ends at this cell
        logic seq_hit;  // cell under the subsequence pointer matches
    } cell_stat_t;

    // Per-beat summary into the tracker
    typedef struct packed {
        logic target;    // accepted target beat
        logic has_char;
        logic last;
        logic tail_any;
        logic seq_hit;
    } trk_beat_t;

    // Tracker status toward the cells
    typedef struct packed {
        logic              cstep;
        logic [QLEN_W-1:0] sidx;
    } trk_stat_t;

    typedef struct packed {
        logic               matched;
        logic [SCORE_W-1:0] score;
    } result_t;

    // ASCII upper to lower case
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/fss_in_if.sv =====
// Input channel interface: query loads and target characters.
// No dependencies.
interface fss_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [5:0] query_index;
    logic [7:0] character;
    logic       has_char;
    logic       last;

    modport source (output valid, opcode, query_index, character, has_char, last,
                    input ready);
    modport sink   (input valid, opcode, query_index, character, has_char, last,
                    output ready);
endinterface

// ===== rtl/core/fss_out_if.sv =====
// Result channel interface: match flag and score.
// No dependencies.
interface fss_out_if;
    logic        valid;
    logic        ready;
    logic        matched;
    logic [13:0] score;

    modport source (output valid, matched, score, input ready);
    modport sink   (input valid, matched, score, output ready);
endinterface

// ===== rtl/core/fss_cfg_if.sv =====
// Configuration write channel interface: query length register.
// No dependencies.
interface fss_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] query_length;

    modport source (output valid, query_length, input ready);
    modport sink   (input valid, query_length, output ready);
endinterface

// ===== rtl/core/fss_cell.sv =====
// One query cell: holds a query character and its shift-and partial-match bit.
// Depends on fss_pkg.
module fss_cell
    import fss_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       load,
    input  logic       pm_left,
    output logic       pm,
    output cell_stat_t stat
);

    logic [CHAR_W-1:0] qchar_reg;
    logic              pm_reg;
    logic              pm_next;
    logic              active;
    logic              hit;
    logic              pm_new;

    // Query character store
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            qchar_reg <= ctrl.tchar;
        end
    end

    // Compare and shift-and update
    always_comb
    begin
        active       = ctrl.qlen > QLEN_W'(IDX);
        hit          = active && (qchar_reg == ctrl.tchar);
        pm_new       = pm_left && hit;
        stat.tail    = pm_new && (ctrl.qlen == QLEN_W'(IDX + 1));
        stat.seq_hit = hit && (ctrl.sidx == QLEN_W'(IDX));
        if (ctrl.clear)
        begin
            pm_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            pm_next = pm_new;
        end
        else
        begin
            pm_next = pm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg <= 1'b0;
        end
        else
        begin
            pm_reg <= pm_next;
        end
    end

    assign pm = pm_reg;

endmodule

// ===== rtl/core/fss_tracker.sv =====
// Per-target tracker: position, substring start, greedy subsequence score, result.
// Depends on fss_pkg.
module fss_tracker
    import fss_pkg::*;
#(
    parameter int MAX_TARGET = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [QLEN_W-1:0] qlen,
    input  trk_beat_t         beat,
    output trk_stat_t         stat,
    output result_t           res
);

    localparam int TPOS_W = $clog2(MAX_TARGET + 1);
    localparam int CW     = (TPOS_W > SPOS_W) ? TPOS_W : SPOS_W;

    logic [TPOS_W-1:0]   tpos_reg, tpos_next, tpos_upd;
    logic                found_reg, found_next, found_upd;
    logic [SPOS_W-1:0]   spos_reg, spos_next, spos_upd;
    logic [QLEN_W-1:0]   sidx_reg, sidx_next, sidx_upd;
    logic [QLEN_W-1:0]   run_reg, run_next, run_upd;
    logic [SSCORE_W-1:0] sscore_reg, sscore_next, sscore_upd;
    logic                bonus_reg, bonus_next, bonus_upd;

    logic                consume;
    logic                cstep;
    logic [TPOS_W-1:0]   tpos_inc;
    logic [CW-1:0]       tpos_x, qlen_x, start;

    always_comb
    begin
        consume  = beat.target && beat.has_char && (tpos_reg < TPOS_W'(MAX_TARGET));
        cstep    = consume && (qlen != '0);
        tpos_inc = tpos_reg + TPOS_W'(1);
        tpos_upd = consume ? tpos_inc : tpos_reg;

        // Substring start, clamped at zero and saturated
        tpos_x = CW'(tpos_inc);
        qlen_x = CW'(qlen);
        start  = (tpos_x >= qlen_x) ? (tpos_x - qlen_x) : '0;

        found_upd = found_reg;
        spos_upd  = spos_reg;
        if (cstep && !found_reg && beat.tail_any)
        begin
            found_upd = 1'b1;
            spos_upd  = (start > CW'(SPOS_MAX)) ? SPOS_W'(SPOS_MAX) : start[SPOS_W-1:0];
        end

        // Greedy subsequence
        sidx_upd   = sidx_reg;
        run_upd    = run_reg;
        sscore_upd = sscore_reg;
        bonus_upd  = bonus_reg;
        if (cstep && (sidx_reg < qlen))
        begin
            if (beat.seq_hit)
            begin
                sscore_upd = sscore_reg + SSCORE_W'(MATCH_BASE)
                           + SSCORE_W'({run_reg, 1'b0}) + SSCORE_W'(run_reg);
                if ((tpos_reg < TPOS_W'(START_WINDOW)) && (sidx_reg == '0))
                begin
                    bonus_upd = 1'b1;
                end
                sidx_upd = sidx_reg + QLEN_W'(1);
                run_upd  = run_reg + QLEN_W'(1);
            end
            else
            begin
                run_upd = '0;
            end
        end

        // Result from the updated state
        res.matched = 1'b0;
        res.score   = '0;
        if (qlen == '0)
        begin
            res.matched = 1'b1;
            res.score   = SCORE_W'(1);
        end
        else if (tpos_upd == '0)
        begin
            res.matched = 1'b0;
        end
        else if (found_upd)
        begin
            res.matched = 1'b1;
            res.score   = (spos_upd == '0) ? SCORE_W'(SCORE_HEAD)
                        : SCORE_W'(SCORE_BASE) - SCORE_W'(spos_upd);
        end
        else if (sidx_upd >= qlen)
        begin
            res.matched = 1'b1;
            res.score   = SCORE_W'(sscore_upd) + (bonus_upd ? SCORE_W'(START_BONUS) : '0);
        end

        // End of target returns everything to its reset value
        if (beat.target && beat.last)
        begin
            tpos_next   = '0;
            found_next  = 1'b0;
            spos_next   = '0;
            sidx_next   = '0;
            run_next    = '0;
            sscore_next = '0;
            bonus_next  = 1'b0;
        end
        else
        begin
            tpos_next   = tpos_upd;
            found_next  = found_upd;
            spos_next   = spos_upd;
            sidx_next   = sidx_upd;
            run_next    = run_upd;
            sscore_next = sscore_upd;
            bonus_next  = bonus_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpos_reg   <= '0;
            found_reg  <= 1'b0;
            spos_reg   <= '0;
            sidx_reg   <= '0;
            run_reg    <= '0;
            sscore_reg <= '0;
            bonus_reg  <= 1'b0;
        end
        else
        begin
            tpos_reg   <= tpos_next;
            found_reg  <= found_next;
            spos_reg   <= spos_next;
            sidx_reg   <= sidx_next;
            run_reg    <= run_next;
            sscore_reg <= sscore_next;
            bonus_reg  <= bonus_next;
        end
    end

    assign stat.cstep = cstep;
    assign stat.sidx  = sidx_reg;

endmodule

// ===== rtl/core/fuzzy_substring_subsequence_scorer.sv =====
// Fuzzy substring/subsequence scorer. A row of MAX_QUERY cells holds the query
// (one character each) and a shift-and partial-match bit; a target character is
// broadcast to all cells and compared in parallel, so the block takes one beat per
// clock: query loads and target characters alike, back to back. The only stall
// is the output register: while a result beat waits and the sink holds ready low,
// input ready is low. The result is registered and valid in the cycle after the last
// beat. Characters are folded to lower case; characters past MAX_TARGET are ignored.
// Query length must be written on the cfg channel only while no target is in flight;
// the block does not enforce it. Depends on fss_pkg, fss_in_if, fss_out_if, fss_cfg_if, fss_cell, fss_tracker.
module fuzzy_substring_subsequence_scorer
    import fss_pkg::*;
#(
    parameter int MAX_QUERY  = 64,
    parameter int MAX_TARGET = 256
)
(
    input logic      clk,
    input logic      rst_n,
    fss_in_if.sink   in,
    fss_cfg_if.sink  cfg,
    fss_out_if.source out
);

    logic [6:0]          query_length_reg;
    logic [QLEN_W-1:0]   qlen;
    logic                in_fire;
    logic                tgt_beat;
    logic [CHAR_W-1:0]   fchar;
    cell_ctrl_t          ctrl;
    trk_beat_t           beat;
    trk_stat_t           tstat;
    result_t             res;
    logic [MAX_QUERY-1:0] pm_vec;
    logic [MAX_QUERY-1:0] tail_vec;
    logic [MAX_QUERY-1:0] seq_vec;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg;

    // Length register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            query_length_reg <= cfg.query_length;
        end
    end

    assign qlen = (query_length_reg > 7'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY)
                                                      : query_length_reg[QLEN_W-1:0];

    // Input handshake
    assign in.ready = !out_valid_reg || out.ready;
    assign in_fire  = in.valid && in.ready;
    assign tgt_beat = in_fire && (in.opcode == OP_TARGET);
    assign fchar    = fold(in.character);

    // Broadcast to the cells
    always_comb
    begin
        ctrl.step  = tstat.cstep;
        ctrl.clear = tgt_beat && in.last;
        ctrl.tchar = fchar;
        ctrl.qlen  = qlen;
        ctrl.sidx  = tstat.sidx;
    end

    // Cell row
    for (genvar i = 0; i < MAX_QUERY; i++)
    begin : g_cell
        logic       load;
        logic       pm_left;
        cell_stat_t cstat;

        assign load    = in_fire && (in.opcode == OP_LOAD)
                      && (in.query_index == QIDX_W'(i));
        assign pm_left = (i == 0) ? 1'b1 : pm_vec[(i == 0) ? 0 : i - 1];

        fss_cell #(.IDX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .load    (load),
            .pm_left (pm_left),
            .pm      (pm_vec[i]),
            .stat    (cstat)
        );

        assign tail_vec[i] = cstat.tail;
        assign seq_vec[i]  = cstat.seq_hit;
    end

    always_comb
    begin
        beat.target   = tgt_beat;
        beat.has_char = in.has_char;
        beat.last     = in.last;
        beat.tail_any = |tail_vec;
        beat.seq_hit  = |seq_vec;
    end

    fss_tracker #(.MAX_TARGET(MAX_TARGET)) u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .qlen  (qlen),
        .beat  (beat),
        .stat  (tstat),
        .res   (res)
    );

    // Output register
    always_comb
    begin
        if (tgt_beat && in.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_beat && in.last)
        begin
            out_res_reg <= res;
        end
    end

    assign out.valid   = out_valid_reg;
    assign out.matched = out_res_reg.matched;
    assign out.score   = out_res_reg.score;

endmodule

// ===== rtl/core/fss_checker.sv =====
// Port-level checks for the scorer, bound to the top level.
// Depends on fss_pkg and fuzzy_substring_subsequence_scorer.
module fss_checker
    import fss_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_opcode,
    input logic               in_last,
    input logic               out_valid,
    input logic               out_ready,
    input logic               out_matched,
    input logic [SCORE_W-1:0] out_score
);

    // A miss always reports a zero score
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_matched |-> out_score == '0)
        else $error("nonzero score on a miss");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_matched) && $stable(out_score))
        else $error("result beat changed while stalled");

    // A new result comes only from an accepted last target beat
    a_rose_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_opcode == OP_TARGET && in_last))
        else $error("result without a last target beat");

    // With the output stage empty the input is never stalled
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

endmodule

bind fuzzy_substring_subsequence_scorer fss_checker u_fss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in.valid),
    .in_ready    (in.ready),
    .in_opcode   (in.opcode),
    .in_last     (in.last),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_matched (out.matched),
    .out_score   (out.score)
);
